FILE: hdl/adam_pkg.sv
// ----------------------------------------------------------------------------
// adam_pkg
// Shared constants and types for the Adam optimizer update unit.
// ----------------------------------------------------------------------------
package adam_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] REG_FIRST_DECAY  = 3'd0;
    localparam logic [2:0] REG_SECOND_DECAY = 3'd1;
    localparam logic [2:0] REG_LEARN_RATE   = 3'd2;
    localparam logic [2:0] REG_FIRST_BIAS   = 3'd3;
    localparam logic [2:0] REG_SECOND_BIAS  = 3'd4;

    localparam logic [15:0] FIRST_DECAY_RST  = 16'd58982;
    localparam logic [15:0] SECOND_DECAY_RST = 16'd65470;
    localparam logic [15:0] LEARN_RATE_RST   = 16'd66;
    localparam logic [31:0] FIRST_BIAS_RST   = 32'd655360;
    localparam logic [31:0] SECOND_BIAS_RST  = 32'd65536000;

    typedef logic signed [32:0] mul_op_t;
    typedef logic signed [65:0] acc_t;

endpackage

FILE: hdl/adam_ram.sv
// ----------------------------------------------------------------------------
// adam_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module adam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: hdl/adam_optimizer_update_unit.sv
// ----------------------------------------------------------------------------
// adam_optimizer_update_unit
// Adam step over a table of Q16.16 coordinates with per-entry moments.
//
//   channel | ports                                   | direction
//   s_      | action, entry_index, operand_value      | in, valid/ready
//   m_      | result_index, coordinate_value, sat'd   | out, valid/ready
//   cfg_    | wr_en, index, wdata                     | in, write only
//
// Load goes straight to DONE and read passes through READ; an update makes nine
// passes through one shared 33x33 multiplier, then a bit-serial square root and
// a restoring divider. One item at a time; s_ready is low while busy.
// Reset is synchronous; the stores are not cleared. A stalled result sits in
// the output register and the next item is accepted meanwhile.
// ----------------------------------------------------------------------------
module adam_optimizer_update_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [2:0]                  cfg_index,
    input  logic [31:0]                 cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [9:0]                  s_entry_index,
    input  logic signed [31:0]          s_operand_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [adam_pkg::IDX_W-1:0]  m_result_index,
    output logic signed [31:0]          m_coordinate_value,
    output logic                        m_saturated
);
    import adam_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_M1    = 4'd2;
    localparam logic [3:0] ST_M2    = 4'd3;
    localparam logic [3:0] ST_M3    = 4'd4;
    localparam logic [3:0] ST_M4    = 4'd5;
    localparam logic [3:0] ST_M5    = 4'd6;
    localparam logic [3:0] ST_M6    = 4'd7;
    localparam logic [3:0] ST_M7    = 4'd8;
    localparam logic [3:0] ST_M8    = 4'd9;
    localparam logic [3:0] ST_M9    = 4'd10;
    localparam logic [3:0] ST_SQRT  = 4'd11;
    localparam logic [3:0] ST_DIVI  = 4'd12;
    localparam logic [3:0] ST_DIV   = 4'd13;
    localparam logic [3:0] ST_APPLY = 4'd14;
    localparam logic [3:0] ST_DONE  = 4'd15;

    localparam logic [33:0] STEP_MAX = 34'h2_0000_0000;

    logic [15:0] fd_reg, sd_reg, lr_reg;
    logic [31:0] s1_reg, s2_reg;

    logic [3:0]             state_reg, state_next;
    logic [1:0]             act_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic signed [31:0]     g_reg;
    logic signed [31:0]     coord_reg, m_reg;
    logic [31:0]            v_reg, gsq_reg;
    logic [47:0]            mhat_reg;
    acc_t                   acc_reg, acc_next;
    logic [63:0]            sq_n_reg;
    logic [33:0]            sq_rem_reg;
    logic [31:0]            root_reg;
    logic [32:0]            den_reg;
    logic [32:0]            dv_rem_reg;
    logic [33:0]            dv_d_reg, dv_q_reg;
    logic [5:0]             cnt_reg;
    logic [IDX_W-1:0]       res_idx_reg;
    logic signed [31:0]     res_val_reg;
    logic                   res_sat_reg;
    logic                   m_valid_reg;
    logic [IDX_W-1:0]       out_idx_reg;
    logic signed [31:0]     out_val_reg;
    logic                   out_sat_reg;

    logic             s_fire;
    logic [IDX_W-1:0] s_idx, ram_addr;
    logic signed [31:0] coord_rd, m_rd;
    logic [31:0]      v_rd;
    logic             coord_we, mv_we;
    logic signed [31:0] coord_wd, m_wd;
    logic [31:0]      v_wd;

    mul_op_t          op_a, op_b;
    logic signed [65:0] prod;
    logic             acc_keep, acc_hi;
    acc_t             acc_rnd;

    logic [32:0]      m_mag, g_mag;
    logic [35:0]      sq_sh, sq_trial, sq_diff;
    logic [32:0]      den_w;
    logic [63:0]      dvd;
    logic [33:0]      dv_sh, dv_diff;
    logic [33:0]      step;
    logic signed [35:0] nv;
    logic signed [31:0] nv_clip;
    logic             nv_sat;

    assign s_idx  = IDX_W'(s_entry_index % ENTRIES);
    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign ram_addr = (state_reg == ST_IDLE) ? s_idx : idx_reg;

    adam_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_coord_ram (
        .aclk(aclk), .wr_en(coord_we), .wr_addr(ram_addr), .wr_data(coord_wd),
        .rd_addr(ram_addr), .rd_data(coord_rd)
    );
    adam_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_m_ram (
        .aclk(aclk), .wr_en(mv_we), .wr_addr(ram_addr), .wr_data(m_wd),
        .rd_addr(ram_addr), .rd_data(m_rd)
    );
    adam_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_v_ram (
        .aclk(aclk), .wr_en(mv_we), .wr_addr(ram_addr), .wr_data(v_wd),
        .rd_addr(ram_addr), .rd_data(v_rd)
    );

    assign m_mag = m_reg[31] ? 33'(-{m_reg[31], m_reg}) : {1'b0, m_reg};
    assign g_mag = g_reg[31] ? 33'(-{g_reg[31], g_reg}) : {1'b0, g_reg};

    // shared multiplier operand select
    always_comb begin
        op_a     = '0;
        op_b     = '0;
        acc_keep = 1'b0;
        acc_hi   = 1'b0;
        unique case (state_reg)
            ST_M1: begin
                op_a = mul_op_t'({17'd0, fd_reg});
                op_b = mul_op_t'({m_reg[31], m_reg});
            end
            ST_M2: begin
                op_a = mul_op_t'({16'd0, 17'(17'h10000 - {1'b0, fd_reg})});
                op_b = mul_op_t'({g_reg[31], g_reg});
                acc_keep = 1'b1;
            end
            ST_M3: begin
                op_a = mul_op_t'(g_mag);
                op_b = mul_op_t'(g_mag);
            end
            ST_M4: begin
                op_a = mul_op_t'({17'd0, sd_reg});
                op_b = mul_op_t'({1'b0, v_reg});
            end
            ST_M5: begin
                op_a = mul_op_t'({16'd0, 17'(17'h10000 - {1'b0, sd_reg})});
                op_b = mul_op_t'({1'b0, gsq_reg});
                acc_keep = 1'b1;
            end
            ST_M6: begin
                op_a = mul_op_t'(m_mag);
                op_b = mul_op_t'({1'b0, s1_reg});
            end
            ST_M7: begin
                op_a = mul_op_t'({1'b0, v_reg});
                op_b = mul_op_t'({1'b0, s2_reg});
            end
            ST_M8: begin
                op_a = mul_op_t'({17'd0, lr_reg});
                op_b = mul_op_t'({1'b0, mhat_reg[31:0]});
            end
            ST_M9: begin
                op_a = mul_op_t'({17'd0, lr_reg});
                op_b = mul_op_t'({17'd0, mhat_reg[47:32]});
                acc_keep = 1'b1;
                acc_hi   = 1'b1;
            end
            default: begin
                acc_keep = 1'b1;
            end
        endcase
    end

    assign prod    = op_a * op_b;
    assign acc_rnd = acc_reg + acc_t'(32768);

    always_comb begin
        if (state_reg >= ST_M1 && state_reg <= ST_M9) begin
            acc_next = (acc_keep ? acc_reg : acc_t'(0))
                     + (acc_hi ? {prod[33:0], 32'd0} : prod);
        end else begin
            acc_next = acc_reg;
        end
    end

    // square root and divider steps
    assign sq_sh    = {sq_rem_reg, sq_n_reg[63:62]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_diff  = sq_sh - sq_trial;
    assign den_w    = {1'b0, root_reg} + 33'd1;
    assign dvd      = acc_reg[63:0] + {32'd0, den_w[32:1]};
    assign dv_sh    = {dv_rem_reg, dv_d_reg[33]};
    assign dv_diff  = dv_sh - {1'b0, den_reg};
    assign step     = (dv_q_reg > STEP_MAX) ? STEP_MAX : dv_q_reg;
    assign nv       = {{4{coord_reg[31]}}, coord_reg}
                    + (m_reg[31] ? $signed({2'b00, step}) : -$signed({2'b00, step}));

    always_comb begin
        if (nv > 36'sh0_7FFF_FFFF) begin
            nv_clip = 32'sh7FFF_FFFF;
            nv_sat  = 1'b1;
        end else if (nv < -36'sh0_8000_0000) begin
            nv_clip = 32'sh8000_0000;
            nv_sat  = 1'b1;
        end else begin
            nv_clip = nv[31:0];
            nv_sat  = 1'b0;
        end
    end

    always_comb begin
        coord_we = 1'b0;
        mv_we    = 1'b0;
        coord_wd = s_operand_value;
        m_wd     = m_reg;
        v_wd     = v_reg;
        if (state_reg == ST_IDLE && s_fire && s_action == ACT_LOAD) begin
            coord_we = 1'b1;
            mv_we    = 1'b1;
            m_wd     = '0;
            v_wd     = '0;
        end else if (state_reg == ST_M7) begin
            mv_we = 1'b1;
        end else if (state_reg == ST_APPLY) begin
            coord_we = 1'b1;
            coord_wd = nv_clip;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_action == ACT_LOAD) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:  state_next = (act_reg == ACT_UPDATE) ? ST_M1 : ST_DONE;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    state_next = ST_M4;
            ST_M4:    state_next = ST_M5;
            ST_M5:    state_next = ST_M6;
            ST_M6:    state_next = ST_M7;
            ST_M7:    state_next = ST_M8;
            ST_M8:    state_next = ST_M9;
            ST_M9:    state_next = ST_SQRT;
            ST_SQRT:  state_next = (cnt_reg == '0) ? ST_DIVI : ST_SQRT;
            ST_DIVI:  state_next = ({4'd0, dvd[63:34]} >= {1'b0, den_w}) ? ST_APPLY : ST_DIV;
            ST_DIV:   state_next = (cnt_reg == '0) ? ST_APPLY : ST_DIV;
            ST_APPLY: state_next = ST_DONE;
            ST_DONE:  state_next = (!m_valid_reg || m_ready) ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            fd_reg      <= FIRST_DECAY_RST;
            sd_reg      <= SECOND_DECAY_RST;
            lr_reg      <= LEARN_RATE_RST;
            s1_reg      <= FIRST_BIAS_RST;
            s2_reg      <= SECOND_BIAS_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FIRST_DECAY:  fd_reg <= cfg_wdata[15:0];
                    REG_SECOND_DECAY: sd_reg <= cfg_wdata[15:0];
                    REG_LEARN_RATE:   lr_reg <= cfg_wdata[15:0];
                    REG_FIRST_BIAS:   s1_reg <= cfg_wdata;
                    REG_SECOND_BIAS:  s2_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && !m_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (state_reg == ST_DONE && m_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        unique case (state_reg)
            ST_IDLE: begin
                act_reg     <= s_action;
                idx_reg     <= s_idx;
                g_reg       <= s_operand_value;
                res_idx_reg <= s_idx;
                res_val_reg <= s_operand_value;
                res_sat_reg <= 1'b0;
            end
            ST_READ: begin
                coord_reg   <= coord_rd;
                m_reg       <= m_rd;
                v_reg       <= v_rd;
                res_val_reg <= coord_rd;
            end
            ST_M3: m_reg <= acc_rnd[47:16];
            ST_M4: gsq_reg <= (acc_reg[65:48] != '0) ? 32'hFFFF_FFFF : acc_reg[47:16];
            ST_M6: v_reg <= (acc_rnd[65:48] != '0) ? 32'hFFFF_FFFF : acc_rnd[47:16];
            ST_M7: mhat_reg <= acc_reg[63:16];
            ST_M8: begin
                sq_n_reg   <= {acc_reg[63:16], 16'd0};
                sq_rem_reg <= '0;
                root_reg   <= '0;
                cnt_reg    <= 6'd31;
            end
            ST_SQRT: begin
                sq_n_reg <= {sq_n_reg[61:0], 2'b00};
                cnt_reg  <= cnt_reg - 6'd1;
                if (sq_sh >= sq_trial) begin
                    sq_rem_reg <= sq_diff[33:0];
                    root_reg   <= {root_reg[30:0], 1'b1};
                end else begin
                    sq_rem_reg <= sq_sh[33:0];
                    root_reg   <= {root_reg[30:0], 1'b0};
                end
            end
            ST_DIVI: begin
                den_reg    <= den_w;
                dv_rem_reg <= {3'd0, dvd[63:34]};
                dv_d_reg   <= dvd[33:0];
                dv_q_reg   <= STEP_MAX;
                cnt_reg    <= 6'd33;
            end
            ST_DIV: begin
                dv_d_reg <= {dv_d_reg[32:0], 1'b0};
                cnt_reg  <= cnt_reg - 6'd1;
                if (dv_sh >= {1'b0, den_reg}) begin
                    dv_rem_reg <= dv_diff[32:0];
                    dv_q_reg   <= {dv_q_reg[32:0], 1'b1};
                end else begin
                    dv_rem_reg <= dv_sh[32:0];
                    dv_q_reg   <= {dv_q_reg[32:0], 1'b0};
                end
            end
            ST_APPLY: begin
                res_val_reg <= nv_clip;
                res_sat_reg <= nv_sat;
            end
            default: ;
        endcase
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            out_idx_reg <= res_idx_reg;
            out_val_reg <= res_val_reg;
            out_sat_reg <= res_sat_reg;
        end
    end

    // commit of the final value happens in APPLY from the computed word
    assign m_valid            = m_valid_reg;
    assign m_result_index     = out_idx_reg;
    assign m_coordinate_value = out_val_reg;
    assign m_saturated        = out_sat_reg;

    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
        (m_coordinate_value == 32'sh7FFF_FFFF || m_coordinate_value == 32'sh8000_0000))
        else $error("saturated beat without a clipped value");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dv_rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_sqrt_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> (cnt_reg <= 6'd31))
        else $error("root step count out of range");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_valid_reg && !m_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Adam update unit. It loads entries, applies
// gradient updates and reads values back under random valid/ready gaps and
// several register settings. A scoreboard predicts every result beat.
// ----------------------------------------------------------------------------
module tb;
    import adam_pkg::*;

    class adam_scoreboard;
        bit [15:0] beta1, beta2, eta;
        bit [31:0] scale1, scale2;
        bit signed [31:0] coord[ENTRIES];
        bit signed [31:0] mom1[ENTRIES];
        bit [31:0] mom2[ENTRIES];
        bit [9:0] q_idx[$];
        bit signed [31:0] q_val[$];
        bit q_sat[$];
        int errors;

        function new();
            beta1 = FIRST_DECAY_RST;
            beta2 = SECOND_DECAY_RST;
            eta = LEARN_RATE_RST;
            scale1 = FIRST_BIAS_RST;
            scale2 = SECOND_BIAS_RST;
            errors = 0;
        endfunction

        function void set_reg(bit [2:0] idx, bit [31:0] val);
            case (idx)
                REG_FIRST_DECAY: beta1 = val[15:0];
                REG_SECOND_DECAY: beta2 = val[15:0];
                REG_LEARN_RATE: eta = val[15:0];
                REG_FIRST_BIAS: scale1 = val;
                REG_SECOND_BIAS: scale2 = val;
                default: ;
            endcase
        endfunction

        function longint rnd16(longint x);
            return (x + 64'sd32768) >>> 16;
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void note_input(bit [1:0] act, bit [9:0] idx, bit signed [31:0] opnd);
            longint g, m, nv;
            longint unsigned gmag, gsq, v, mmag, mhat, vhat, den, num, stp;
            bit neg, sat;
            sat = 0;
            if (act == ACT_LOAD) begin
                coord[idx] = opnd;
                mom1[idx] = 0;
                mom2[idx] = 0;
            end else if (act == ACT_UPDATE) begin
                g = opnd;
                gmag = g < 0 ? -g : g;
                gsq = (gmag * gmag) >> 16;
                if (gsq > 64'hFFFFFFFF) gsq = 64'hFFFFFFFF;
                m = rnd16(longint'(beta1) * mom1[idx] + (65536 - longint'(beta1)) * g);
                v = rnd16(longint'(beta2) * mom2[idx] + (65536 - longint'(beta2)) * gsq);
                if (v > 64'hFFFFFFFF) v = 64'hFFFFFFFF;
                mom1[idx] = 32'(m);
                mom2[idx] = 32'(v);
                neg = m < 0;
                mmag = neg ? -m : m;
                mhat = (mmag * scale1) >> 16;
                vhat = (v * scale2) >> 16;
                den = int_root(vhat << 16) + 1;
                num = eta * mhat;
                stp = (num + (den >> 1)) / den;
                if (stp > (64'd1 << 33)) stp = 64'd1 << 33;
                nv = longint'(coord[idx]) + (neg ? longint'(stp) : -longint'(stp));
                if (nv > 64'sd2147483647) begin
                    nv = 64'sd2147483647;
                    sat = 1;
                end else if (nv < -64'sd2147483648) begin
                    nv = -64'sd2147483648;
                    sat = 1;
                end
                coord[idx] = 32'(nv);
            end
            q_idx.push_back(idx);
            q_val.push_back(coord[idx]);
            q_sat.push_back(sat);
        endfunction

        function void check_result(bit [9:0] idx, bit signed [31:0] val, bit sat);
            bit [9:0] ei;
            bit signed [31:0] ev;
            bit es;
            if (q_idx.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat idx=%0d", idx);
                return;
            end
            ei = q_idx.pop_front();
            ev = q_val.pop_front();
            es = q_sat.pop_front();
            if (ei !== idx || ev !== val || es !== sat) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp idx=%0d val=%h sat=%0d got idx=%0d val=%h sat=%0d",
                             ei, ev, es, idx, val, sat);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_action = '0;
    logic [9:0] s_entry_index = '0;
    logic signed [31:0] s_operand_value = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [IDX_W-1:0] m_result_index;
    logic signed [31:0] m_coordinate_value;
    logic m_saturated;

    adam_scoreboard sb;
    bit loaded[ENTRIES];
    int loaded_list[$];
    int cycles = 0;
    int hold_off = 0;
    bit stim_done = 0;

    adam_optimizer_update_unit dut (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int w;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off > 0) begin
                m_ready <= 0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (w > 0) begin
                m_ready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_result(m_result_index, m_coordinate_value, m_saturated);
        end
    end

    task automatic send_beat(bit [1:0] act, bit [9:0] idx, bit signed [31:0] opnd,
                             bit do_gap = 1);
        int w;
        w = do_gap ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18)) : 0;
        if (w > 0) begin
            s_valid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_valid <= 1;
        s_action <= act;
        s_entry_index <= idx;
        s_operand_value <= opnd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(act, idx, opnd);
        if (act == ACT_LOAD && !loaded[idx]) begin
            loaded[idx] = 1;
            loaded_list.push_back(idx);
        end
    endtask

    task automatic write_reg(bit [2:0] idx, bit [31:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.q_idx.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic bit signed [31:0] rand_grad();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 4095)) - 2048;
            2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
        endcase
    endfunction

    task automatic random_phase(int n);
        int i;
        bit [9:0] idx;
        int r;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (loaded_list.size() == 0 || r == 0) begin
                idx = 10'($urandom);
                send_beat(ACT_LOAD, idx, $urandom);
            end else begin
                idx = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
                if (r < 8) send_beat(ACT_UPDATE, idx, rand_grad());
                else send_beat(r == 8 ? ACT_READ : ACT_UNUSED, idx, $urandom);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, every action, unused action, saturation
        send_beat(ACT_LOAD, 10'd0, 32'sh7FFFFFFF);
        send_beat(ACT_LOAD, 10'd1023, 32'sh80000000);
        send_beat(ACT_LOAD, 10'd5, 32'sd0);
        send_beat(ACT_READ, 10'd0, 32'sh12345678);
        send_beat(ACT_UNUSED, 10'd1023, 32'shFFFFFFFF);
        send_beat(ACT_UPDATE, 10'd0, 32'sh80000000);
        send_beat(ACT_UPDATE, 10'd1023, 32'sh7FFFFFFF);
        send_beat(ACT_UPDATE, 10'd5, 32'sd0);
        send_beat(ACT_UPDATE, 10'd5, 32'sd1);
        send_beat(ACT_UPDATE, 10'd5, -32'sd1);
        send_beat(ACT_UPDATE, 10'd0, 32'sh80000000);
        send_beat(ACT_READ, 10'd1023, 32'sd0);
        drain();

        write_reg(REG_LEARN_RATE, 32'hFFFF);
        write_reg(REG_FIRST_BIAS, 32'hFFFFFFFF);
        write_reg(REG_SECOND_BIAS, 32'h00010000);
        write_reg(REG_FIRST_DECAY, 32'h0);
        write_reg(REG_SECOND_DECAY, 32'h0);
        send_beat(ACT_UPDATE, 10'd0, 32'sh80000000);
        send_beat(ACT_UPDATE, 10'd1023, 32'sh7FFFFFFF);
        send_beat(ACT_UPDATE, 10'd5, 32'sh00000100);
        random_phase(300);
        drain();

        write_reg(REG_FIRST_DECAY, 32'hFFFF);
        write_reg(REG_SECOND_DECAY, 32'hFFFF);
        write_reg(REG_LEARN_RATE, 32'h0);
        write_reg(REG_FIRST_BIAS, 32'h00010000);
        write_reg(REG_SECOND_BIAS, 32'hFFFFFFFF);
        random_phase(250);
        drain();

        write_reg(REG_FIRST_DECAY, 32'(FIRST_DECAY_RST));
        write_reg(REG_SECOND_DECAY, 32'(SECOND_DECAY_RST));
        write_reg(REG_LEARN_RATE, 32'd6554);
        write_reg(REG_FIRST_BIAS, FIRST_BIAS_RST);
        write_reg(REG_SECOND_BIAS, SECOND_BIAS_RST);
        // long receiver hold-off while the sender keeps offering beats
        hold_off = 400;
        for (int i = 0; i < 20; i++)
            send_beat(ACT_LOAD, 10'($urandom), $urandom, 0);
        random_phase(400);
        drain();

        write_reg(REG_FIRST_DECAY, $urandom_range(0, 65535));
        write_reg(REG_SECOND_DECAY, $urandom_range(0, 65535));
        write_reg(REG_LEARN_RATE, $urandom_range(0, 65535));
        write_reg(REG_FIRST_BIAS, $urandom_range(32'h10000, 32'h7FFFFFFF));
        write_reg(REG_SECOND_BIAS, $urandom_range(32'h10000, 32'h7FFFFFFF));
        random_phase(400);
        drain();

        if (sb.errors == 0 && sb.q_idx.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
